>>> hdl/wmdu_pkg.sv
// Package: shared types and constants for the word multiply/divide unit.
`timescale 1ns / 1ps
package wmdu_pkg;

  localparam logic [1:0] OP_MULU = 2'd0;
  localparam logic [1:0] OP_MULS = 2'd1;
  localparam logic [1:0] OP_DIVU = 2'd2;
  localparam logic [1:0] OP_DIVS = 2'd3;

  localparam logic [7:0] CYC_MUL_BASE = 8'd38;
  localparam logic [7:0] CYC_DIVU     = 8'd140;
  localparam logic [7:0] CYC_DIVS     = 8'd120;
  localparam logic [7:0] CYC_DIV_ZERO = 8'd38;
  localparam logic [7:0] CYC_DIVU_OVF = 8'd10;
  localparam logic [7:0] CYC_DIVS_OVF = 8'd12;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] source_value;
    logic [31:0] dest_value;
  } req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        write_dest;
    logic        n_flag;
    logic        z_flag;
    logic        nz_written;
    logic        v_flag;
    logic        c_flag;
    logic        divide_by_zero;
    logic [7:0]  base_cycles;
  } rsp_t;

endpackage

>>> hdl/wmdu_if.sv
// Interfaces: valid/ready channels for request and response beats.
`timescale 1ns / 1ps
interface wmdu_req_if;
  import wmdu_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wmdu_rsp_if;
  import wmdu_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/wmdu_div_stage.sv
// One divider pipeline stage: STEPS restoring divide steps on a magnitude pair.
`timescale 1ns / 1ps
module wmdu_div_stage #(
  parameter int STEPS = 4
) (
  input  logic [31:0] rem_in,   // partial remainder (upper part of dividend shifting in)
  input  logic [31:0] num_in,   // remaining dividend bits, msb first
  input  logic [15:0] den,
  input  logic [16:0] quo_in,
  output logic [31:0] rem_out,
  output logic [31:0] num_out,
  output logic [16:0] quo_out
);
  import wmdu_pkg::*;

  always_comb begin
    logic [32:0] trial;
    logic [31:0] r;
    logic [31:0] nm;
    logic [16:0] q;
    r  = rem_in;
    nm = num_in;
    q  = quo_in;
    for (int i = 0; i < STEPS; i++) begin
      r     = {r[30:0], nm[31]};
      nm    = {nm[30:0], 1'b0};
      trial = {1'b0, r} - {17'd0, den};
      q     = {q[15:0], ~trial[32]};
      if (!trial[32]) begin
        r = trial[31:0];
      end
    end
    rem_out = r;
    num_out = nm;
    quo_out = q;
  end

endmodule

>>> hdl/word_multiply_divide_unit.sv
// Top level: pipelined word multiply/divide unit with N/Z/V/C and cycle count.
`timescale 1ns / 1ps
// Executes MULU, MULS, DIVU and DIVS on a 16-bit source and 32-bit destination.
// Fully pipelined: one operation may enter every clock unless the output
// stalls, and passes through NST stages (one prep stage, the divider steps
// over stages two to six, four steps a stage and one in the last, with the
// multiplier registered alongside, one finish stage). The divider array sets
// the depth. The whole pipe advances when the output register is empty or
// taken, so a stalled sink holds every beat in place; else one beat per cycle.
module word_multiply_divide_unit (
  input logic clk,
  input logic rst_n,
  wmdu_req_if.sink   in_ch,
  wmdu_rsp_if.source out_ch
);
  import wmdu_pkg::*;

  localparam int NDIV = 5;   // divider stages, 4 steps each and 1 in the last -> 17 bits
  localparam int NST  = NDIV + 2;

  typedef struct packed {
    logic [1:0]  op;
    logic        sneg;       // dividend negative (signed divide)
    logic        qneg;
    logic        dz;
    logic [7:0]  mcyc;
    logic [31:0] prod;
  } side_t;

  logic         adv;
  logic [NST-1:0] vld_r;

  side_t        sd_r  [NDIV+1];
  logic [31:0]  rem_r [NDIV+1];
  logic [31:0]  num_r [NDIV+1];
  logic [16:0]  quo_r [NDIV+1];
  logic [15:0]  den_r [NDIV+1];
  rsp_t         out_r;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld_r[NST-1];
  assign out_ch.data  = out_r;

  // ---------------- stage 0: operand prep ----------------
  logic [15:0] s_in, lo_in;
  logic [31:0] t_in, ta_in;
  logic [15:0] sa_in;
  logic        tneg, sneg_in, sgn;
  logic [16:0] sx, lx;
  logic signed [33:0] mprod;
  logic [15:0] tr, cnt_src;
  logic [4:0]  pop;
  side_t       sd0_nxt;

  always_comb begin
    s_in    = in_ch.data.source_value;
    t_in    = in_ch.data.dest_value;
    lo_in   = t_in[15:0];
    sgn     = (in_ch.data.req_type == OP_DIVS);
    tneg    = sgn && t_in[31];
    sneg_in = sgn && s_in[15];
    ta_in   = tneg ? (32'd0 - t_in) : t_in;
    sa_in   = sneg_in ? (16'd0 - s_in) : s_in;
    // MULS counts bit transitions of the source with a zero shifted in below
    tr      = s_in ^ {s_in[14:0], 1'b0};
    cnt_src = (in_ch.data.req_type == OP_MULS) ? tr : s_in;
    pop     = '0;
    for (int i = 0; i < 16; i++) begin
      pop = pop + {4'd0, cnt_src[i]};
    end
    sd0_nxt.op   = in_ch.data.req_type;
    sd0_nxt.sneg = tneg;
    sd0_nxt.qneg = tneg ^ sneg_in;
    sd0_nxt.dz   = (s_in == 16'd0);
    sd0_nxt.mcyc = CYC_MUL_BASE + {2'b0, pop, 1'b0};
    sd0_nxt.prod = '0;
  end

  // signed or unsigned 17x17 product from stage-0 operands
  always_comb begin
    sx    = {(sd_r[0].op == OP_MULS) & den_r[0][15], den_r[0]};
    lx    = {(sd_r[0].op == OP_MULS) & num_r[0][15], num_r[0][15:0]};
    mprod = $signed(sx) * $signed(lx);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0]  <= sd0_nxt;
      rem_r[0] <= '0;
      // multiplies keep raw operands in num/den; divides carry magnitudes
      num_r[0] <= (in_ch.data.req_type[1]) ? ta_in : {16'd0, lo_in};
      den_r[0] <= (in_ch.data.req_type[1]) ? sa_in : s_in;
      quo_r[0] <= '0;
    end
  end

  // ---------------- divider stages (with multiply at stage 1) -------------
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    logic [31:0] rem_o, num_o;
    logic [16:0] quo_o;
    logic [31:0] rem_i, num_i;
    side_t       sd_nxt;

    // first stage preloads the 15 leading dividend bits into the remainder; they
    // only bear quotient bits of weight 2^17 or more, which overflow via bit 16
    always_comb begin
      if (g == 0) begin
        rem_i = {17'd0, num_r[0][31:17]};
        num_i = {num_r[0][16:0], 15'd0};
      end else begin
        rem_i = rem_r[g];
        num_i = num_r[g];
      end
      sd_nxt = sd_r[g];
      if (g == 0) begin
        sd_nxt.prod = mprod[31:0];
      end
    end

    wmdu_div_stage #(.STEPS((g == NDIV - 1) ? 1 : 4)) u_stage (
      .rem_in (rem_i),
      .num_in (num_i),
      .den    (den_r[g]),
      .quo_in (quo_r[g]),
      .rem_out(rem_o),
      .num_out(num_o),
      .quo_out(quo_o)
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        sd_r[g+1]  <= sd_nxt;
        rem_r[g+1] <= rem_o;
        num_r[g+1] <= num_o;
        quo_r[g+1] <= quo_o;
        den_r[g+1] <= den_r[g];
      end
    end
  end

  // ---------------- finish stage ----------------
  rsp_t  out_nxt;
  side_t sf;
  logic [16:0] qa;
  logic [15:0] ra, q16, r16;
  logic        ovf;

  always_comb begin
    sf  = sd_r[NDIV];
    qa  = quo_r[NDIV];
    ra  = rem_r[NDIV][15:0];
    q16 = sf.qneg ? (16'd0 - qa[15:0]) : qa[15:0];
    r16 = sf.sneg ? (16'd0 - ra) : ra;
    if (sf.op == OP_DIVU) begin
      ovf = qa[16];
    end else begin
      ovf = sf.qneg ? (qa > 17'd32768) : (qa > 17'd32767);
    end
    out_nxt = '0;
    out_nxt.nz_written = 1'b1;
    case (sf.op)
      OP_MULU, OP_MULS: begin
        out_nxt.result_value = sf.prod;
        out_nxt.write_dest   = 1'b1;
        out_nxt.n_flag       = sf.prod[31];
        out_nxt.z_flag       = (sf.prod == 32'd0);
        out_nxt.base_cycles  = sf.mcyc;
      end
      OP_DIVU, OP_DIVS: begin
        if (sf.dz) begin
          out_nxt.divide_by_zero = 1'b1;
          out_nxt.base_cycles    = CYC_DIV_ZERO;
        end else if (ovf) begin
          out_nxt.v_flag      = 1'b1;
          out_nxt.nz_written  = 1'b0;
          out_nxt.base_cycles = (sf.op == OP_DIVU) ? CYC_DIVU_OVF : CYC_DIVS_OVF;
        end else begin
          out_nxt.result_value = {r16, q16};
          out_nxt.write_dest   = 1'b1;
          out_nxt.n_flag       = q16[15];
          out_nxt.z_flag       = (q16 == 16'd0);
          out_nxt.base_cycles  = (sf.op == OP_DIVU) ? CYC_DIVU : CYC_DIVS;
        end
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("stalled response beat changed");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted beat lost at pipe entry");
  a_c_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !out_ch.data.c_flag)
    else $error("carry flag set");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.data.write_dest &&
                       (out_ch.data.v_flag || out_ch.data.divide_by_zero)))
    else $error("destination written on overflow or zero divide");
`endif

endmodule
